// ----- rtl/fcrp_pkg.sv -----
`default_nettype none

package fcrp_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [CNT_W-1:0] MAX_ENT     = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] FIRST_FREE  = CNT_W'(2);
  localparam logic [IDX_W-1:0] FIRST_DATA  = IDX_W'(2);
  localparam logic [11:0]      BAD_MARK    = 12'hFF7;
  localparam logic [11:0]      END_MIN     = 12'hFF8;
  localparam logic [11:0]      END_MARK    = 12'hFFF;

  // register index, taken from the word address bit
  localparam logic REG_TOTAL_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [9:0] {
    S_SWEEP  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_LOAD   = 10'b0000001000,
    S_QREAD  = 10'b0000010000,
    S_AINIT  = 10'b0000100000,
    S_AREAD  = 10'b0001000000,
    S_ACHECK = 10'b0010000000,
    S_ATERM  = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic sweep;
    logic sweep_old;
    logic capture;
    logic load;
    logic a_init;
    logic a_take;
    logic a_skip;
    logic a_oos;
    logic a_term;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
    logic start_ok;
    logic nf_out;
    logic pin_hit;
    logic walk_more;
  } stat_t;

  typedef struct packed {
    logic [IDX_W-1:0] chain_head;
    logic [CNT_W-1:0] assigned_count;
    logic             out_of_space;
    logic [11:0]      new_entry;
    logic [IDX_W-1:0] source_cluster;
    logic [IDX_W-1:0] target_cluster;
    logic             pinned;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/fcrp_if.sv -----
`default_nettype none

interface fcrp_in_if;
  import fcrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] index;
  logic [11:0]      entry_value;
  modport source (output valid, opcode, index, entry_value, input ready);
  modport sink (input valid, opcode, index, entry_value, output ready);
endinterface

interface fcrp_out_if;
  import fcrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] chain_head;
  logic [CNT_W-1:0] assigned_count;
  logic             out_of_space;
  logic [11:0]      new_entry;
  logic [IDX_W-1:0] source_cluster;
  logic [IDX_W-1:0] target_cluster;
  logic             pinned;
  modport source (output valid, chain_head, assigned_count, out_of_space, new_entry,
                  source_cluster, target_cluster, pinned, input ready);
  modport sink (input valid, chain_head, assigned_count, out_of_space, new_entry,
                source_cluster, target_cluster, pinned, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcrp_ctrl.sv -----
`default_nettype none

module fcrp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fcrp_pkg::stat_t stat,
  output fcrp_pkg::cmd_t  cmd
);
  import fcrp_pkg::*;

  state_t state_r, state_nxt;
  logic   sweep_res_r, sweep_res_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    sweep_res_nxt = sweep_res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_old = sweep_res_r;
        if (stat.sweep_last) begin
          state_nxt = sweep_res_r ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_LOAD:   state_nxt = S_LOAD;
          OP_ASSIGN: state_nxt = S_AINIT;
          OP_QUERY:  state_nxt = S_QREAD;
          OP_CLEAR: begin
            state_nxt     = S_SWEEP;
            sweep_res_nxt = 1'b1;
          end
          default:   state_nxt = S_RESULT;
        endcase
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_QREAD: begin
        state_nxt = S_RESULT;
      end
      S_AINIT: begin
        cmd.a_init = 1'b1;
        state_nxt  = stat.start_ok ? S_AREAD : S_ATERM;
      end
      S_AREAD: begin
        if (stat.nf_out) begin
          cmd.a_oos = 1'b1;
          state_nxt = S_ATERM;
        end else begin
          state_nxt = S_ACHECK;
        end
      end
      S_ACHECK: begin
        if (stat.pin_hit) begin
          cmd.a_skip = 1'b1;
          state_nxt  = S_AREAD;
        end else begin
          cmd.a_take = 1'b1;
          state_nxt  = stat.walk_more ? S_AREAD : S_ATERM;
        end
      end
      S_ATERM: begin
        cmd.a_term = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          sweep_res_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_SWEEP;
        sweep_res_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_res_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_res_r <= sweep_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("item accepted but controller stayed idle");

  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !in_ready)
    else $error("input ready during clearing sweep");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/fcrp_dp.sv -----
`default_nettype none

module fcrp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcrp_pkg::cmd_t                cmd,
  output fcrp_pkg::stat_t               stat,
  input  logic [1:0]                    in_opcode,
  input  logic [fcrp_pkg::IDX_W-1:0]    in_index,
  input  logic [11:0]                   in_entry_value,
  input  logic [fcrp_pkg::CNT_W-1:0]    total_entries,
  output fcrp_pkg::res_t                res
);
  import fcrp_pkg::*;

  // item word
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  logic [11:0]      val_r;

  // sweep and walk state
  logic [IDX_W-1:0] sweep_cnt_r;
  logic [CNT_W-1:0] nf_r;
  logic [CNT_W-1:0] lim_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] steps_r;
  logic [IDX_W-1:0] cl_r;
  logic [IDX_W-1:0] prev_r;
  logic [IDX_W-1:0] start_r;
  logic             have_prev_r;
  logic             oos_r;
  res_t             res_r;
  res_t             res_nxt;

  // stores
  logic [11:0]      old_mem [MAX_ENTRIES];
  logic [11:0]      new_mem [MAX_ENTRIES];
  logic             pin_mem [MAX_ENTRIES];
  logic [IDX_W-1:0] t2s_mem [MAX_ENTRIES];
  logic [IDX_W-1:0] s2t_mem [MAX_ENTRIES];

  logic [11:0]      old_rd_r;
  logic [11:0]      new_rd_r;
  logic             pin_rd_r;
  logic [IDX_W-1:0] t2s_rd_r;
  logic [IDX_W-1:0] s2t_rd_r;

  logic [CNT_W-1:0] lim_c;
  logic [CNT_W-1:0] steps_inc;
  logic [IDX_W-1:0] nf_idx;

  logic             old_we;
  logic [IDX_W-1:0] old_wa;
  logic [11:0]      old_wd;
  logic             new_we;
  logic [IDX_W-1:0] new_wa;
  logic [11:0]      new_wd;
  logic             pin_we;
  logic [IDX_W-1:0] pin_wa;
  logic             pin_wd;
  logic [IDX_W-1:0] pin_ra;
  logic             t2s_we;
  logic [IDX_W-1:0] t2s_wa;
  logic [IDX_W-1:0] t2s_wd;
  logic             s2t_we;
  logic [IDX_W-1:0] s2t_wa;
  logic [IDX_W-1:0] s2t_wd;

  assign lim_c     = (total_entries > MAX_ENT) ? MAX_ENT : total_entries;
  assign steps_inc = steps_r + CNT_W'(1);
  assign nf_idx    = nf_r[IDX_W-1:0];

  always_comb begin
    stat.op         = op_r;
    stat.sweep_last = &sweep_cnt_r;
    stat.start_ok   = (idx_r >= FIRST_DATA) && ({1'b0, idx_r} < lim_c);
    stat.nf_out     = (nf_r >= lim_r);
    stat.pin_hit    = pin_rd_r;
    stat.walk_more  = (old_rd_r < BAD_MARK) && (old_rd_r >= FIRST_DATA) &&
                      ({1'b0, old_rd_r} < lim_r) && (steps_inc < lim_r);
  end

  // write ports
  always_comb begin
    old_we = (cmd.sweep && cmd.sweep_old) || cmd.load;
    old_wa = cmd.sweep ? sweep_cnt_r : idx_r;
    old_wd = cmd.sweep ? 12'd0 : val_r;

    new_we = cmd.sweep || (cmd.load && ((idx_r < FIRST_DATA) || (val_r == BAD_MARK))) ||
             ((cmd.a_take || cmd.a_term) && have_prev_r);
    priority if (cmd.sweep) begin
      new_wa = sweep_cnt_r;
      new_wd = 12'd0;
    end else if (cmd.load) begin
      new_wa = idx_r;
      new_wd = val_r;
    end else if (cmd.a_take) begin
      new_wa = prev_r;
      new_wd = nf_idx;
    end else begin
      new_wa = prev_r;
      new_wd = END_MARK;
    end

    pin_we = cmd.sweep || (cmd.load && (idx_r >= FIRST_DATA));
    pin_wa = cmd.sweep ? sweep_cnt_r : idx_r;
    pin_wd = cmd.sweep ? (sweep_cnt_r < FIRST_DATA) : (val_r == BAD_MARK);
    pin_ra = (op_r == OP_QUERY) ? idx_r : nf_idx;

    t2s_we = cmd.sweep || cmd.a_take;
    t2s_wa = cmd.sweep ? sweep_cnt_r : nf_idx;
    t2s_wd = cmd.sweep ? '0 : cl_r;

    s2t_we = cmd.sweep || cmd.a_take;
    s2t_wa = cmd.sweep ? sweep_cnt_r : cl_r;
    s2t_wd = cmd.sweep ? '0 : nf_idx;
  end

  always_ff @(posedge clk) begin
    if (old_we) begin
      old_mem[old_wa] <= old_wd;
    end
    old_rd_r <= old_mem[cl_r];
  end

  always_ff @(posedge clk) begin
    if (new_we) begin
      new_mem[new_wa] <= new_wd;
    end
    new_rd_r <= new_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (pin_we) begin
      pin_mem[pin_wa] <= pin_wd;
    end
    pin_rd_r <= pin_mem[pin_ra];
  end

  always_ff @(posedge clk) begin
    if (t2s_we) begin
      t2s_mem[t2s_wa] <= t2s_wd;
    end
    t2s_rd_r <= t2s_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (s2t_we) begin
      s2t_mem[s2t_wa] <= s2t_wd;
    end
    s2t_rd_r <= s2t_mem[idx_r];
  end

  // item word, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_opcode);
      idx_r <= in_index;
      val_r <= in_entry_value;
    end
  end

  // walk and allocator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      nf_r        <= FIRST_FREE;
      lim_r       <= MAX_ENT;
      count_r     <= '0;
      steps_r     <= '0;
      cl_r        <= '0;
      prev_r      <= '0;
      start_r     <= '0;
      have_prev_r <= 1'b0;
      oos_r       <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt_r <= sweep_cnt_r + IDX_W'(1);
        nf_r        <= FIRST_FREE;
      end
      if (cmd.a_init) begin
        lim_r       <= lim_c;
        cl_r        <= idx_r;
        count_r     <= '0;
        steps_r     <= '0;
        start_r     <= '0;
        have_prev_r <= 1'b0;
        oos_r       <= 1'b0;
      end
      if (cmd.a_oos) begin
        oos_r <= 1'b1;
      end
      if (cmd.a_skip) begin
        nf_r <= nf_r + CNT_W'(1);
      end
      if (cmd.a_take) begin
        nf_r        <= nf_r + CNT_W'(1);
        count_r     <= count_r + CNT_W'(1);
        steps_r     <= steps_inc;
        prev_r      <= nf_idx;
        have_prev_r <= 1'b1;
        cl_r        <= old_rd_r;
        if (!have_prev_r) begin
          start_r <= nf_idx;
        end
      end
    end
  end

  // result register
  always_comb begin
    res_nxt = '0;
    if (op_r == OP_ASSIGN) begin
      res_nxt.chain_head     = start_r;
      res_nxt.assigned_count = count_r;
      res_nxt.out_of_space   = oos_r;
    end
    if (op_r == OP_QUERY) begin
      res_nxt.new_entry      = new_rd_r;
      res_nxt.source_cluster = t2s_rd_r;
      res_nxt.target_cluster = s2t_rd_r;
      res_nxt.pinned         = pin_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.a_take |-> (nf_r < lim_r))
    else $error("target taken beyond entries in use");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lim_r)
    else $error("assigned count exceeds entries in use");

  a_free_above_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r >= FIRST_FREE)
    else $error("allocator pointer fell into reserved clusters");
`endif

endmodule

`default_nettype wire

// ----- rtl/fat12_chain_relocation_planner.sv -----
`default_nettype none

// FAT12 chain relocation planner. Every word on in_ch gives exactly one word
// on out_ch. After reset, and after each clear word, the block sweeps its
// tables one entry a cycle and takes no input meanwhile; the result of a clear
// word appears when that sweep ends, and only that sweep clears the old table.
// A load word and a query word pass through the decode state and a load or
// read state to the result state, which loads the output register. An assign
// word walks the chain, one step per cluster assigned and per pinned target
// the allocator steps over; each step reads the old table and the pinned map
// once through their registered read ports and then decides. One word is in
// work at a time; the next is accepted while a result still waits in the
// output register. total_entries sits at byte address 0 of the cfg_ port; the
// user must write it only while the block is idle, as the block does not enforce it.

module fat12_chain_relocation_planner (
  input  logic                          clk,
  input  logic                          rst_n,
  fcrp_in_if.sink                       in_ch,
  fcrp_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fcrp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fcrp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fcrp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import fcrp_pkg::*;

  logic [CNT_W-1:0] total_r;
  logic             cfg_wr;
  logic             reg_sel;
  cmd_t             cmd;
  stat_t            stat;
  res_t             res;
  logic             in_ready;
  logic             out_valid;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_AW-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else if (cfg_wr && (reg_sel == REG_TOTAL_ENTRIES)) begin
      total_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = (reg_sel == REG_TOTAL_ENTRIES) ?
                      {{(CFG_DW-CNT_W){1'b0}}, total_r} : '0;

  fcrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcrp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_index       (in_ch.index),
    .in_entry_value (in_ch.entry_value),
    .total_entries  (total_r),
    .res            (res)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.chain_head     = res.chain_head;
  assign out_ch.assigned_count = res.assigned_count;
  assign out_ch.out_of_space   = res.out_of_space;
  assign out_ch.new_entry      = res.new_entry;
  assign out_ch.source_cluster = res.source_cluster;
  assign out_ch.target_cluster = res.target_cluster;
  assign out_ch.pinned         = res.pinned;

endmodule

`default_nettype wire

// ----- tb/fcrp_checker.sv -----
`timescale 1ns / 100ps

module fcrp_checker
  import fcrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [IDX_W-1:0] in_index,
  input  logic [11:0]      in_entry_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [IDX_W-1:0] out_chain_head,
  input  logic [CNT_W-1:0] out_assigned_count,
  input  logic             out_out_of_space,
  input  logic [11:0]      out_new_entry,
  input  logic [IDX_W-1:0] out_source_cluster,
  input  logic [IDX_W-1:0] out_target_cluster,
  input  logic             out_pinned,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic             cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int               failures,
  output int               outstanding
);

  logic [11:0] old_fat [MAX_ENTRIES];
  logic [11:0] new_fat [MAX_ENTRIES];
  logic        pin_map [MAX_ENTRIES];
  logic [11:0] tgt_src [MAX_ENTRIES];
  logic [11:0] src_tgt [MAX_ENTRIES];
  int          alloc_ptr;
  int          fat_limit;
  res_t        planned_results [$];
  int          fail_count = 0;
  int          result_no = 0;

  function automatic void wipe_plan();
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      old_fat[k] = '0;
      new_fat[k] = '0;
      pin_map[k] = 1'b0;
      tgt_src[k] = '0;
      src_tgt[k] = '0;
    end
    pin_map[0] = 1'b1;
    pin_map[1] = 1'b1;
    alloc_ptr = 2;
  endfunction

  function automatic res_t plan_word(op_t op, int idx, logic [11:0] val);
    res_t r;
    int   lim;
    int   cl;
    int   steps;
    int   count;
    int   prev;
    int   tgt;
    bit   linked;
    r = '0;
    lim = (fat_limit > MAX_ENTRIES) ? MAX_ENTRIES : fat_limit;
    case (op)
      OP_LOAD: begin
        old_fat[idx] = val;
        if (idx < 2) begin
          new_fat[idx] = val;
        end else begin
          pin_map[idx] = (val == BAD_MARK);
          if (val == BAD_MARK) new_fat[idx] = BAD_MARK;
        end
      end
      OP_ASSIGN: begin
        cl = idx;
        steps = 0;
        count = 0;
        prev = 0;
        linked = 1'b0;
        while (cl >= 2 && cl < lim && steps < lim) begin
          steps++;
          while (alloc_ptr < lim && pin_map[alloc_ptr]) alloc_ptr++;
          if (alloc_ptr >= lim) begin
            r.out_of_space = 1'b1;
            break;
          end
          tgt = alloc_ptr;
          alloc_ptr++;
          tgt_src[tgt] = cl[11:0];
          src_tgt[cl] = tgt[11:0];
          if (linked) new_fat[prev] = tgt[11:0];
          else r.chain_head = tgt[11:0];
          prev = tgt;
          linked = 1'b1;
          count++;
          if (old_fat[cl] >= END_MIN || old_fat[cl] == BAD_MARK) break;
          cl = old_fat[cl];
        end
        if (linked) new_fat[prev] = END_MARK;
        r.assigned_count = count[CNT_W-1:0];
      end
      OP_QUERY: begin
        r.new_entry = new_fat[idx];
        r.source_cluster = tgt_src[idx];
        r.target_cluster = src_tgt[idx];
        r.pinned = pin_map[idx];
      end
      default: begin
        wipe_plan();
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (!rst_n) begin
      wipe_plan();
      fat_limit = TOTAL_RESET;
      planned_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_TOTAL_ENTRIES)
        fat_limit = cfg_pwdata[CNT_W-1:0];
      if (out_valid && out_ready) begin
        seen.chain_head     = out_chain_head;
        seen.assigned_count = out_assigned_count;
        seen.out_of_space   = out_out_of_space;
        seen.new_entry      = out_new_entry;
        seen.source_cluster = out_source_cluster;
        seen.target_cluster = out_target_cluster;
        seen.pinned         = out_pinned;
        if (planned_results.size() == 0) begin
          if (fail_count < 10)
            $display("result word %0d arrived with nothing planned", result_no);
          fail_count++;
        end else begin
          want = planned_results.pop_front();
          if (seen !== want) begin
            if (fail_count < 10) begin
              $display("result word %0d expected head %h count %0d oos %b entry %h src %h tgt %h pin %b",
                       result_no, want.chain_head, want.assigned_count, want.out_of_space,
                       want.new_entry, want.source_cluster, want.target_cluster,
                       want.pinned);
              $display("result word %0d got head %h count %0d oos %b entry %h src %h tgt %h pin %b",
                       result_no, seen.chain_head, seen.assigned_count, seen.out_of_space,
                       seen.new_entry, seen.source_cluster, seen.target_cluster,
                       seen.pinned);
            end
            fail_count++;
          end
        end
        result_no++;
      end
      if (in_valid && in_ready)
        planned_results.push_back(plan_word(op_t'(in_opcode), in_index, in_entry_value));
    end
    failures <= fail_count;
    outstanding <= planned_results.size();
  end

endmodule

// ----- tb/fat12_chain_relocation_planner_test.sv -----
`timescale 1ns / 100ps

module fat12_chain_relocation_planner_test;
  import fcrp_pkg::*;

  localparam int NUM_WORDS   = 1650;
  localparam int NUM_PHASES  = 10;
  localparam int STALL_LIMIT = 60000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int          failures;
  int          outstanding;
  int          words_sent = 0;
  int          stall_cycles = 0;
  bit          no_gaps = 1'b0;
  int          walk_limit = MAX_ENTRIES;
  bit          fat_written [MAX_ENTRIES];
  logic [11:0] fat_shadow [MAX_ENTRIES];
  int          phase_limit [NUM_PHASES] = '{4096, 3, 8191, 37, 0, 4096, 12, 300, 2, 4095};

  fcrp_in_if  in_ch ();
  fcrp_out_if out_ch ();

  fat12_chain_relocation_planner DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fcrp_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_opcode          (in_ch.opcode),
    .in_index           (in_ch.index),
    .in_entry_value     (in_ch.entry_value),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_chain_head     (out_ch.chain_head),
    .out_assigned_count (out_ch.assigned_count),
    .out_out_of_space   (out_ch.out_of_space),
    .out_new_entry      (out_ch.new_entry),
    .out_source_cluster (out_ch.source_cluster),
    .out_target_cluster (out_ch.target_cluster),
    .out_pinned         (out_ch.pinned),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_pready         (cfg_pready),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .failures           (failures),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic void forget_fat();
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      fat_written[k] = 1'b0;
      fat_shadow[k] = '0;
    end
  endfunction

  // first never-loaded cluster that a walk from start could read, or -1
  function automatic int unwritten_on_path(int start);
    int cl;
    int steps;
    cl = start;
    steps = 0;
    while (cl >= 2 && cl < walk_limit && steps < walk_limit) begin
      if (!fat_written[cl]) return cl;
      steps++;
      if (fat_shadow[cl] >= BAD_MARK) return -1;
      cl = fat_shadow[cl];
    end
    return -1;
  endfunction

  function automatic int pick_end();
    case ($urandom_range(0, 5))
      0: return BAD_MARK;
      1, 2: return $urandom_range(END_MIN, END_MARK);
      3: return $urandom_range(0, 1);
      4: return (walk_limit < MAX_ENTRIES) ? $urandom_range(walk_limit, 4095) : END_MARK;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_cluster();
    if (walk_limit >= 3) return $urandom_range(2, walk_limit - 1);
    return $urandom_range(2, 4095);
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, (walk_limit + 1 > 4095) ? 4095 : walk_limit + 1);
  endfunction

  task automatic send_word(input op_t op, input int idx, input int val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.index       <= idx[11:0];
    in_ch.entry_value <= val[11:0];
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (op == OP_LOAD) begin
      fat_written[idx] = 1'b1;
      fat_shadow[idx] = val[11:0];
    end else if (op == OP_CLEAR) begin
      forget_fat();
    end
  endtask

  task automatic send_assign(input int start);
    int hole;
    hole = unwritten_on_path(start);
    while (hole >= 0) begin
      send_word(OP_LOAD, hole, ($urandom_range(0, 1) == 0) ? pick_end() : pick_cluster());
      hole = unwritten_on_path(start);
    end
    send_word(OP_ASSIGN, start, $urandom_range(0, 4095));
  endtask

  task automatic send_chain();
    int len;
    int first;
    int cur;
    int nxt;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    first = pick_cluster();
    cur = first;
    for (int k = 1; k < len; k++) begin
      nxt = pick_cluster();
      send_word(OP_LOAD, cur, nxt);
      cur = nxt;
    end
    if ($urandom_range(0, 19) == 0) send_word(OP_LOAD, cur, first);
    else send_word(OP_LOAD, cur, pick_end());
    send_assign(first);
  endtask

  task automatic send_noise_load();
    int val;
    case ($urandom_range(0, 3))
      0: val = BAD_MARK;
      1: val = $urandom_range(0, 4095);
      2: val = $urandom_range(0, (walk_limit + 1 > 4095) ? 4095 : walk_limit + 1);
      default: val = pick_end();
    endcase
    send_word(OP_LOAD, pick_index(), val);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_limit(input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TOTAL_ENTRIES, 2'b00};
    cfg_pwdata  <= CFG_DW'(value[CNT_W-1:0]);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    walk_limit = (value[CNT_W-1:0] > MAX_ENTRIES) ? MAX_ENTRIES : value[CNT_W-1:0];
  endtask

  initial begin
    int phase_end;
    int quota;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_LOAD;
    in_ch.index       <= '0;
    in_ch.entry_value <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    forget_fat();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, 4095, 0);
    send_word(OP_LOAD, 0, 'hABC);
    send_word(OP_LOAD, 1, END_MARK);
    send_word(OP_LOAD, 2, 3);
    send_word(OP_LOAD, 3, 4);
    send_word(OP_LOAD, 4, END_MIN);
    send_assign(2);
    send_word(OP_QUERY, 2, 0);
    // bad cluster in the allocator's way
    send_word(OP_LOAD, 5, BAD_MARK);
    send_word(OP_LOAD, 6, END_MARK);
    send_assign(6);
    // unpinning keeps the bad mark in the new table
    send_word(OP_LOAD, 5, 0);
    send_word(OP_QUERY, 5, 0);
    send_word(OP_LOAD, 7, 1);
    send_assign(7);
    send_word(OP_LOAD, 4095, END_MARK);
    send_assign(4095);
    send_word(OP_ASSIGN, 0, 0);
    send_word(OP_ASSIGN, 1, 0);
    // self loop runs the allocator dry
    send_word(OP_LOAD, 8, 8);
    send_assign(8);
    send_word(OP_QUERY, 4095, 0);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_QUERY, 2, 0);

    quota = (NUM_WORDS - words_sent) / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      program_limit(phase_limit[p]);
      send_word(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
      phase_end = words_sent + quota;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        case ($urandom_range(0, 99)) inside
          [0:54]:  send_chain();
          [55:69]: send_noise_load();
          [70:84]: send_word(OP_QUERY, pick_index(), $urandom_range(0, 4095));
          [85:96]: send_assign(pick_index());
          default: send_word(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
        endcase
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
